[design/assert_macros.svh]
// Shared assertion shorthands for the distinct-run tracker checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Antecedent implies consequent at the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

[design/ldrt_pkg.sv]
package ldrt_pkg;

  localparam int SYM_W = 8;   // input symbol width
  localparam int OUT_W = 8;   // result width
  localparam int GROUP = 16;  // cells per first-level OR group

  // per-cycle command broadcast to every window cell
  typedef struct packed {
    logic clear;    // terminator: empty the window
    logic compare;  // new symbol: latch per-cell hit
    logic shift;    // drop oldest: every cell takes its younger-side neighbor
  } cell_ctl_t;

endpackage

[design/ldrt_stream_if.sv]
interface ldrt_in_if;
  logic                       valid;
  logic                       ready;
  logic [ldrt_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface ldrt_out_if;
  logic                       valid;
  logic                       ready;
  logic [ldrt_pkg::OUT_W-1:0] longest_run;

  modport source (output valid, output longest_run, input ready);
  modport sink   (input valid, input longest_run, output ready);
endinterface

[design/ldrt_cell.sv]
// One window slot. Oldest symbol lives in cell 0; a shift moves every
// slot one step toward cell 0.
module ldrt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ldrt_pkg::cell_ctl_t        ctl,
  input  logic                       wr_sel,
  input  logic [ldrt_pkg::SYM_W-1:0] wr_sym,
  input  logic [ldrt_pkg::SYM_W-1:0] cmp_sym,
  input  logic [ldrt_pkg::SYM_W-1:0] nb_sym,
  input  logic                       nb_valid,
  input  logic                       nb_match,
  output logic [ldrt_pkg::SYM_W-1:0] sym,
  output logic                       valid,
  output logic                       match
);

  logic [ldrt_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic                       valid_r, valid_nxt;
  logic                       match_r, match_nxt;

  always_comb begin
    sym_nxt   = sym_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
      match_nxt = 1'b0;
    end else begin
      if (ctl.compare) begin
        match_nxt = valid_r && (sym_r == cmp_sym);
      end
      if (ctl.shift) begin
        sym_nxt   = nb_sym;
        valid_nxt = nb_valid;
        match_nxt = nb_match;
      end
      if (wr_sel) begin
        sym_nxt   = wr_sym;
        valid_nxt = 1'b1;
        match_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  assign sym   = sym_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

[design/ldrt_hit_reduce.sv]
// Two-level OR of the per-cell hit flags; first level registered.
module ldrt_hit_reduce #(
  parameter int CELLS = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CELLS-1:0] hits,
  output logic             present
);

  localparam int GROUPS = (CELLS + ldrt_pkg::GROUP - 1) / ldrt_pkg::GROUP;
  localparam int PW     = GROUPS * ldrt_pkg::GROUP;

  typedef logic [PW-1:0] pad_t;

  pad_t              padded;
  logic [GROUPS-1:0] group_r, group_nxt;

  assign padded = pad_t'(hits);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_nxt[g] = |padded[g*ldrt_pkg::GROUP +: ldrt_pkg::GROUP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
    end else begin
      group_r <= group_nxt;
    end
  end

  assign present = |group_r;

endmodule

[design/longest_distinct_run_tracker.sv]
// Longest run of distinct bytes in a zero-terminated byte stream. Each
// nonzero symbol passes through REDUCE and DECIDE before ready returns,
// and through DROP while symbols leave the window: the per-cell hit
// flags go through a registered OR tree before the decision, and the
// drop loop moves the window chain one cell per cycle. A terminator is
// transferred only when the result register is free or being drained;
// it loads the best length into that register and empties the window
// at once. Nonzero symbols are taken while a result still waits. Symbols
// at or above SYMBOL_COUNT are consumed and ignored. No clearing pass
// follows reset; reset itself clears the per-cell valid flags.
module longest_distinct_run_tracker #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  ldrt_in_if.sink           in_ch,
  ldrt_out_if.source        out_ch
);

  // window holds at most SYMBOL_COUNT-1 distinct nonzero symbols
  localparam int CELLS = SYMBOL_COUNT - 1;
  localparam int LEN_W = $clog2(SYMBOL_COUNT);

  // sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;  // ready for a symbol
  localparam logic [1:0] S_REDUCE = 2'd1;  // hit flags into OR tree
  localparam logic [1:0] S_DECIDE = 2'd2;  // append, or start dropping
  localparam logic [1:0] S_DROP   = 2'd3;  // drop oldest until the hit leaves

  logic [1:0]                 state_r, state_nxt;
  logic [ldrt_pkg::SYM_W-1:0] pend_r, pend_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [LEN_W-1:0]           best_r, best_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ldrt_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                       in_ready;
  logic                       accept;
  logic                       is_term;
  logic                       in_range;
  logic                       present;

  ldrt_pkg::cell_ctl_t        ctl;
  logic                       wr_en;
  logic [LEN_W-1:0]           wr_idx;

  logic [ldrt_pkg::SYM_W-1:0] cell_sym   [CELLS];
  logic                       cell_valid [CELLS];
  logic [CELLS-1:0]           cell_match;

  // terminator needs the result register; other symbols do not
  assign in_ready = (state_r == S_IDLE) && (!is_term || !out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ready;
  assign is_term  = (in_ch.symbol == '0);
  assign in_range = ({1'b0, in_ch.symbol} < (ldrt_pkg::SYM_W + 1)'(SYMBOL_COUNT));

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    len_nxt       = len_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    wr_en         = 1'b0;
    wr_idx        = len_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_term) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = ldrt_pkg::OUT_W'(best_r);
            len_nxt       = '0;
            best_nxt      = '0;
            ctl.clear     = 1'b1;
          end else if (in_range) begin
            // every cell checks itself against the new symbol
            pend_nxt    = in_ch.symbol;
            ctl.compare = 1'b1;
            state_nxt   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (present) begin
          state_nxt = S_DROP;
        end else begin
          // symbol is new to the window: append at the young end
          wr_en     = 1'b1;
          wr_idx    = len_r;
          len_nxt   = len_r + 1'b1;
          if ((len_r + 1'b1) > best_r) begin
            best_nxt = len_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DROP: begin
        ctl.shift = 1'b1;
        if (cell_match[0]) begin
          // the repeat itself leaves; new copy goes in the freed young slot,
          // so the length stays the same and cannot beat the best
          wr_en     = 1'b1;
          wr_idx    = len_r - 1'b1;
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = len_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window chain: cell i takes cell i+1 on a shift
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [ldrt_pkg::SYM_W-1:0] nb_sym;
    logic                       nb_valid;
    logic                       nb_match;
    logic                       wr_sel;

    if (i == CELLS - 1) begin : g_tail
      assign nb_sym   = '0;
      assign nb_valid = 1'b0;
      assign nb_match = 1'b0;
    end else begin : g_body
      assign nb_sym   = cell_sym[i+1];
      assign nb_valid = cell_valid[i+1];
      assign nb_match = cell_match[i+1];
    end

    assign wr_sel = wr_en && (wr_idx == LEN_W'(i));

    ldrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_sel   (wr_sel),
      .wr_sym   (pend_r),
      .cmp_sym  (in_ch.symbol),
      .nb_sym   (nb_sym),
      .nb_valid (nb_valid),
      .nb_match (nb_match),
      .sym      (cell_sym[i]),
      .valid    (cell_valid[i]),
      .match    (cell_match[i])
    );
  end

  ldrt_hit_reduce #(
    .CELLS (CELLS)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .hits    (cell_match),
    .present (present)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.longest_run = out_data_r;

endmodule

[design/ldrt_checker.sv]
`include "assert_macros.svh"

module ldrt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [ldrt_pkg::SYM_W-1:0] in_symbol,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ldrt_pkg::OUT_W-1:0] out_longest_run
);

  logic in_xfer;
  logic term_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign term_xfer = in_xfer && (in_symbol == '0);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_longest_run))
  // a terminator always yields a result on the next cycle
  `ASSERT_NEXT(a_term_result, clk, rst_n, term_xfer, out_valid)
  // a string byte never creates a result by itself
  `ASSERT_NEXT(a_no_spurious, clk, rst_n, in_xfer && (in_symbol != '0) && !out_valid, !out_valid)
  // a drained result goes away unless a new terminator came with it
  `ASSERT_NEXT(a_drain, clk, rst_n, out_valid && out_ready && !term_xfer, !out_valid)

endmodule

bind longest_distinct_run_tracker ldrt_checker u_ldrt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_symbol       (in_ch.symbol),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_longest_run (out_ch.longest_run)
);
